// ===== sv/pld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_pkg: shared types and constants for the packet loss and delay emulator
// Holds the loss mode codes, register indexes, field widths and the structs
// that carry configuration and decision state between modules.
// ----------------------------------------------------------------------------
package pld_pkg;

  // Random fractions are unsigned fixed point with this many fraction bits.
  localparam int FRACTION_BITS = 16;

  localparam int DRAW_W  = 16;  // loss_draw, delay_draw
  localparam int RATE_W  = 17;  // drop_rate, loss_after_loss
  localparam int CHAIN_W = 16;  // chain_length, chain position
  localparam int BOUND_W = 16;  // delay_min, delay_max
  localparam int DELAY_W = 17;  // delay_ms result
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [1:0] {
    LOSS_NONE    = 2'd0,
    LOSS_INDEP   = 2'd1,
    LOSS_MARKOV  = 2'd2,
    LOSS_CHAINED = 2'd3
  } loss_mode_t;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_RATE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_AFTER_LOSS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MODE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MIN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MAX       = 3'd6;

  typedef struct packed {
    loss_mode_t           loss_mode;
    logic [RATE_W-1:0]    drop_rate;
    logic [RATE_W-1:0]    loss_after_loss;
    logic [CHAIN_W-1:0]   chain_length;
    logic                 delay_mode;
    logic [BOUND_W-1:0]   delay_min;
    logic [BOUND_W-1:0]   delay_max;
  } cfg_t;

  typedef struct packed {
    logic                 previous_lost;
    logic [CHAIN_W-1:0]   chain_position;
    logic                 chain_decision;
  } loss_state_t;

endpackage

// ===== sv/packet_loss_delay_emulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_loss_delay_emulator: per-packet loss decision and uniform delay
// For each request of two random fractions the block returns one result:
// a lost flag and a delay in milliseconds, following one of four loss
// models (none, independent, two-state Markov or chained).
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | slave     | in_tvalid/tready   | tdata: loss_draw, delay_draw
//  out_    | master    | out_tvalid/tready  | tdata: delay_ms; tuser: lost
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data
//
// One request is accepted every cycle when the result side keeps up. A
// request is held in the input register and then moves to the result
// register, from which its result is offered. The rate is set by the
// single decision stage between them, which holds one 17 x 16 multiply
// for the delay scaling and the
// compares for the loss.
// Reset (rst_n low, synchronous) clears the pipeline, the loss state and
// every configuration register, except chain_length, which returns to one.
// A stalled result side holds both registers; in_tready then drops, and
// rises again in the same cycle that out_tready frees the result slot.
// Configuration writes are always taken and should be made while idle.
// ----------------------------------------------------------------------------
module packet_loss_delay_emulator (
  input  logic        clk,
  input  logic        rst_n,
  // Input requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] loss_draw, [31:16] delay_draw
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [16:0] delay_ms, [23:17] zero
  output logic [0:0]  out_tuser,   // [0] lost
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pld_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  pld_pkg::cfg_t cfg_r;

  // Loss state carried from packet to packet.
  pld_pkg::loss_state_t state_r;
  pld_pkg::loss_state_t state_nxt;

  // Input register.
  logic                         in_valid_r;
  logic [pld_pkg::DRAW_W-1:0]   loss_draw_r;
  logic [pld_pkg::DRAW_W-1:0]   delay_draw_r;

  // Result register.
  logic                         out_valid_r;
  logic                         out_lost_r;
  logic [pld_pkg::DELAY_W-1:0]  out_delay_r;

  // Decision outputs.
  logic                         lost;
  logic [pld_pkg::DELAY_W-1:0]  delay_ms;
  logic [pld_pkg::BOUND_W-1:0]  delay_lo;
  logic [pld_pkg::BOUND_W-1:0]  delay_hi;

  logic in_accept;
  logic res_load;

  // The result slot is free when empty or being drained this cycle; the
  // input register moves forward exactly when the result slot can take it.
  assign res_load  = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || res_load;
  assign in_accept = in_tvalid && in_tready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loss_mode       <= pld_pkg::LOSS_NONE;
      cfg_r.drop_rate       <= '0;
      cfg_r.loss_after_loss <= '0;
      cfg_r.chain_length    <= pld_pkg::CHAIN_W'(1);
      cfg_r.delay_mode      <= 1'b0;
      cfg_r.delay_min       <= '0;
      cfg_r.delay_max       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pld_pkg::REG_LOSS_MODE:
          cfg_r.loss_mode <= pld_pkg::loss_mode_t'(cfg_data[1:0]);
        pld_pkg::REG_DROP_RATE:
          cfg_r.drop_rate <= cfg_data[pld_pkg::RATE_W-1:0];
        pld_pkg::REG_LOSS_AFTER_LOSS:
          cfg_r.loss_after_loss <= cfg_data[pld_pkg::RATE_W-1:0];
        pld_pkg::REG_CHAIN_LENGTH:
          cfg_r.chain_length <= cfg_data[pld_pkg::CHAIN_W-1:0];
        pld_pkg::REG_DELAY_MODE:
          cfg_r.delay_mode <= cfg_data[0];
        pld_pkg::REG_DELAY_MIN:
          cfg_r.delay_min <= cfg_data[pld_pkg::BOUND_W-1:0];
        pld_pkg::REG_DELAY_MAX:
          cfg_r.delay_max <= cfg_data[pld_pkg::BOUND_W-1:0];
        default: begin
          // Unknown indexes are ignored.
        end
      endcase
    end
  end

  // Input register: valid is control, the draws are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      loss_draw_r  <= in_tdata[15:0];
      delay_draw_r <= in_tdata[31:16];
    end
  end

  pld_decide u_decide (
    .cfg        (cfg_r),
    .state      (state_r),
    .loss_draw  (loss_draw_r),
    .delay_draw (delay_draw_r),
    .lost       (lost),
    .delay_ms   (delay_ms),
    .delay_lo   (delay_lo),
    .delay_hi   (delay_hi),
    .state_nxt  (state_nxt)
  );

  // Loss state advances once per packet, when its decision is committed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (res_load) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_lost_r  <= lost;
      out_delay_r <= delay_ms;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24-pld_pkg::DELAY_W){1'b0}}, out_delay_r};
  assign out_tuser  = out_lost_r;

  // With loss disabled no packet is ever dropped.
  a_none_never_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && (cfg_r.loss_mode == pld_pkg::LOSS_NONE)) |=> !out_lost_r)
    else $error("packet dropped with loss mode none");

  // Chain state only moves in chained mode.
  a_chain_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && (cfg_r.loss_mode != pld_pkg::LOSS_CHAINED)) |=>
      ($stable(state_r.chain_position) && $stable(state_r.chain_decision)))
    else $error("chain state changed outside chained mode");

  // A uniform delay stays inside the (ordered) bounds.
  a_delay_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && cfg_r.delay_mode) |=>
      ((out_delay_r >= {1'b0, $past(delay_lo)}) &&
       (out_delay_r <= {1'b0, $past(delay_hi)})))
    else $error("delay outside configured bounds");

  // Delay disabled means a zero delay.
  a_delay_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && !cfg_r.delay_mode) |=> (out_delay_r == '0))
    else $error("nonzero delay with delay mode off");

  // Back pressure only comes from a full pipeline with a stalled result side.
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule

// ===== sv/pld_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_decide: loss decision and delay computation for one packet
// Combinational stage: picks the loss threshold from the mode and state,
// compares it with the draw, and scales the delay draw into the delay range.
// ----------------------------------------------------------------------------
module pld_decide (
  input  pld_pkg::cfg_t                     cfg,
  input  pld_pkg::loss_state_t              state,
  input  logic [pld_pkg::DRAW_W-1:0]        loss_draw,
  input  logic [pld_pkg::DRAW_W-1:0]        delay_draw,
  output logic                              lost,
  output logic [pld_pkg::DELAY_W-1:0]       delay_ms,
  output logic [pld_pkg::BOUND_W-1:0]       delay_lo,
  output logic [pld_pkg::BOUND_W-1:0]       delay_hi,
  output pld_pkg::loss_state_t              state_nxt
);

  localparam int SPAN_W = pld_pkg::BOUND_W + 1;
  localparam int PROD_W = SPAN_W + pld_pkg::DRAW_W;

  logic [pld_pkg::RATE_W-1:0]  draw_ext;
  logic [pld_pkg::RATE_W-1:0]  markov_thr;
  logic [pld_pkg::CHAIN_W-1:0] chain_len;
  logic [pld_pkg::CHAIN_W:0]   chain_next;
  logic                        below_rate;
  logic                        below_markov;
  logic [SPAN_W-1:0]           span;
  logic [PROD_W-1:0]           product;
  logic [pld_pkg::DELAY_W-1:0] scaled;

  assign draw_ext     = {{(pld_pkg::RATE_W-pld_pkg::DRAW_W){1'b0}}, loss_draw};
  assign markov_thr   = state.previous_lost ? cfg.loss_after_loss : cfg.drop_rate;
  assign below_rate   = draw_ext < cfg.drop_rate;
  assign below_markov = draw_ext < markov_thr;

  // A zero chain length behaves like a length of one.
  assign chain_len  = (cfg.chain_length == '0) ? pld_pkg::CHAIN_W'(1) : cfg.chain_length;
  assign chain_next = {1'b0, state.chain_position} + (pld_pkg::CHAIN_W+1)'(1);

  always_comb begin
    state_nxt = state;
    lost      = 1'b0;
    unique case (cfg.loss_mode)
      pld_pkg::LOSS_NONE: begin
        lost = 1'b0;
      end
      pld_pkg::LOSS_INDEP: begin
        lost = below_rate;
      end
      pld_pkg::LOSS_MARKOV: begin
        lost                    = below_markov;
        state_nxt.previous_lost = below_markov;
      end
      pld_pkg::LOSS_CHAINED: begin
        if (state.chain_position == '0) begin
          state_nxt.chain_decision = below_rate;
        end
        lost = (state.chain_position == '0) ? below_rate : state.chain_decision;
        // Wrap also covers a chain length that shrank below the position.
        state_nxt.chain_position = (chain_next >= {1'b0, chain_len}) ? '0 :
                                   chain_next[pld_pkg::CHAIN_W-1:0];
      end
      default: begin
        lost = 1'b0;
      end
    endcase
  end

  // Reversed bounds are swapped so the smaller one is the minimum.
  assign delay_lo = (cfg.delay_min > cfg.delay_max) ? cfg.delay_max : cfg.delay_min;
  assign delay_hi = (cfg.delay_min > cfg.delay_max) ? cfg.delay_min : cfg.delay_max;

  assign span    = {1'b0, delay_hi} + SPAN_W'(1) - {1'b0, delay_lo};
  assign product = PROD_W'(span) * PROD_W'(delay_draw);
  assign scaled  = product[pld_pkg::FRACTION_BITS +: pld_pkg::DELAY_W];

  assign delay_ms = cfg.delay_mode ?
                    ({{(pld_pkg::DELAY_W-pld_pkg::BOUND_W){1'b0}}, delay_lo} + scaled) :
                    '0;

endmodule

// ===== bench/loss_delay_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loss_delay_checker: result predictor and comparator for the loss emulator
// Tracks configuration writes and accepted requests, keeps its own copy of
// the loss state, and compares each accepted result with the oldest
// prediction. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module loss_delay_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [31:0]                    in_tdata,    // [15:0] loss_draw, [31:16] delay_draw
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [23:0]                    out_tdata,   // [16:0] delay_ms, [23:17] zero
  input  logic [0:0]                     out_tuser,   // [0] lost
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pld_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             failures,
  output int                             outstanding
);

  typedef struct packed {
    logic                        lost;
    logic [pld_pkg::DELAY_W-1:0] delay_ms;
  } packet_fate_t;

  pld_pkg::cfg_t         emu_cfg;
  pld_pkg::loss_state_t  emu_state;
  packet_fate_t          predicted_fates[$];

  // Works out the fate of one packet and advances the loss state.
  function automatic packet_fate_t decide_packet(
      input logic [pld_pkg::DRAW_W-1:0] loss_draw,
      input logic [pld_pkg::DRAW_W-1:0] delay_draw);
    packet_fate_t fate;
    logic [pld_pkg::RATE_W-1:0] threshold;
    logic [16:0] run_len, next_pos, lo, hi, span;
    logic [32:0] scaled;
    fate = '0;
    case (emu_cfg.loss_mode)
      pld_pkg::LOSS_INDEP: fate.lost = ({1'b0, loss_draw} < emu_cfg.drop_rate);
      pld_pkg::LOSS_MARKOV: begin
        threshold = emu_state.previous_lost ? emu_cfg.loss_after_loss : emu_cfg.drop_rate;
        emu_state.previous_lost = ({1'b0, loss_draw} < threshold);
        fate.lost = emu_state.previous_lost;
      end
      pld_pkg::LOSS_CHAINED: begin
        run_len  = (emu_cfg.chain_length == '0) ? 17'd1 : {1'b0, emu_cfg.chain_length};
        next_pos = {1'b0, emu_state.chain_position} + 17'd1;
        if (emu_state.chain_position == '0) begin
          emu_state.chain_decision = ({1'b0, loss_draw} < emu_cfg.drop_rate);
        end
        fate.lost = emu_state.chain_decision;
        emu_state.chain_position = (next_pos >= run_len) ? '0 : next_pos[15:0];
      end
      default: fate.lost = 1'b0;
    endcase
    if (emu_cfg.delay_mode) begin
      lo = {1'b0, emu_cfg.delay_min};
      hi = {1'b0, emu_cfg.delay_max};
      if (lo > hi) begin
        lo = {1'b0, emu_cfg.delay_max};
        hi = {1'b0, emu_cfg.delay_min};
      end
      span = hi + 17'd1 - lo;
      scaled = {16'd0, span} * {17'd0, delay_draw};
      fate.delay_ms = lo + scaled[32:16];
    end
    return fate;
  endfunction

  always @(posedge clk) begin
    packet_fate_t oldest;
    if (!rst_n) begin
      emu_cfg = '0;
      emu_cfg.chain_length = 16'd1;
      emu_state = '0;
      predicted_fates.delete();
      failures = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pld_pkg::REG_LOSS_MODE:
            emu_cfg.loss_mode = pld_pkg::loss_mode_t'(cfg_data[1:0]);
          pld_pkg::REG_DROP_RATE:       emu_cfg.drop_rate       = cfg_data[16:0];
          pld_pkg::REG_LOSS_AFTER_LOSS: emu_cfg.loss_after_loss = cfg_data[16:0];
          pld_pkg::REG_CHAIN_LENGTH:    emu_cfg.chain_length    = cfg_data[15:0];
          pld_pkg::REG_DELAY_MODE:      emu_cfg.delay_mode      = cfg_data[0];
          pld_pkg::REG_DELAY_MIN:       emu_cfg.delay_min       = cfg_data[15:0];
          pld_pkg::REG_DELAY_MAX:       emu_cfg.delay_max       = cfg_data[15:0];
          default: ;
        endcase
      end
      // A result can never belong to a request taken at the same edge, so
      // the comparison runs before the new prediction is queued.
      if (out_tvalid && out_tready) begin
        if (predicted_fates.size() == 0) begin
          $display("%0t: result with no request waiting, got delay %0d lost %0d",
                   $time, out_tdata[16:0], out_tuser[0]);
          failures++;
        end else begin
          oldest = predicted_fates.pop_front();
          if (out_tdata !== {7'd0, oldest.delay_ms}) begin
            $display("%0t: delay_ms mismatch, expected 0x%06h, got 0x%06h",
                     $time, {7'd0, oldest.delay_ms}, out_tdata);
            failures++;
          end
          if (out_tuser[0] !== oldest.lost) begin
            $display("%0t: lost mismatch, expected %0d, got %0d",
                     $time, oldest.lost, out_tuser[0]);
            failures++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_fates.push_back(decide_packet(in_tdata[15:0], in_tdata[31:16]));
      end
    end
    outstanding = predicted_fates.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the packet loss and delay emulator
// Drives a short directed sequence over every loss mode and delay corner,
// then about a thousand random requests under several random settings and
// three flow-control regimes. A separate checker predicts every result.
// ----------------------------------------------------------------------------
module testbench;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [pld_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // Extra idle cycles after the last result has come out, kept for margin.
  localparam int SETTLE_CYCLES  = 6;
  // Cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTINGS_PER_REGIME = 6;
  localparam int PACKETS_PER_SETTING = 56;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [31:0]                    in_tdata = '0;    // [15:0] loss_draw, [31:16] delay_draw
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [23:0]                    out_tdata;        // [16:0] delay_ms, [23:17] zero
  logic [0:0]                     out_tuser;        // [0] lost
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pld_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pld_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int failures;
  int outstanding;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct = 20;
  int recv_stall_pct = 88;

  // Current loss thresholds, used to aim draws at the compare boundary.
  logic [pld_pkg::RATE_W-1:0] cur_rate = '0;
  logic [pld_pkg::RATE_W-1:0] cur_after_loss = '0;

  int idle_cycles = 0;

  packet_loss_delay_emulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  loss_delay_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at random with the current stall percentage.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Any accepted request, result or register write counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one packet request, possibly after a random gap, and returns at
  // the falling edge after it has been accepted with in_tvalid still high.
  task automatic send_packet(input logic [pld_pkg::DRAW_W-1:0] loss_draw,
                             input logic [pld_pkg::DRAW_W-1:0] delay_draw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {delay_draw, loss_draw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the sender back until every predicted result has come out, then
  // lets the pipeline run empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [pld_pkg::CFG_IDX_W-1:0] index,
                           input logic [pld_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random bits above a register's width, present half of the time; the
  // block must drop them.
  function automatic logic [pld_pkg::CFG_DATA_W-1:0] junk_above(input int width);
    logic [pld_pkg::CFG_DATA_W-1:0] noise;
    noise = pld_pkg::CFG_DATA_W'($urandom);
    return $urandom_range(1) ? ((noise >> width) << width) : '0;
  endfunction

  // Rewrites every register while the block is idle. The loss state is not
  // touched by configuration, so chains and Markov memory carry over.
  task automatic program_emulator(input pld_pkg::loss_mode_t        mode,
                                  input logic [pld_pkg::RATE_W-1:0]  rate,
                                  input logic [pld_pkg::RATE_W-1:0]  after_loss,
                                  input logic [pld_pkg::CHAIN_W-1:0] chain_len,
                                  input logic                        delay_on,
                                  input logic [pld_pkg::BOUND_W-1:0] delay_lo,
                                  input logic [pld_pkg::BOUND_W-1:0] delay_hi);
    settle();
    cfg_write(pld_pkg::REG_LOSS_MODE,
              junk_above(2) | pld_pkg::CFG_DATA_W'(mode));
    cfg_write(pld_pkg::REG_DROP_RATE,       rate);
    cfg_write(pld_pkg::REG_LOSS_AFTER_LOSS, after_loss);
    cfg_write(pld_pkg::REG_CHAIN_LENGTH,
              junk_above(16) | pld_pkg::CFG_DATA_W'(chain_len));
    cfg_write(pld_pkg::REG_DELAY_MODE,
              junk_above(1) | pld_pkg::CFG_DATA_W'(delay_on));
    cfg_write(pld_pkg::REG_DELAY_MIN,
              junk_above(16) | pld_pkg::CFG_DATA_W'(delay_lo));
    cfg_write(pld_pkg::REG_DELAY_MAX,
              junk_above(16) | pld_pkg::CFG_DATA_W'(delay_hi));
    cfg_write(REG_SPARE, pld_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    cur_rate = rate;
    cur_after_loss = after_loss;
  endtask

  function automatic logic [pld_pkg::RATE_W-1:0] pick_rate();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 17'h10000;
      2:       return pld_pkg::RATE_W'($urandom_range(4096));
      3:       return pld_pkg::RATE_W'($urandom_range(61440, 65536));
      default: return pld_pkg::RATE_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [pld_pkg::CHAIN_W-1:0] pick_chain_len();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      default: return pld_pkg::CHAIN_W'($urandom_range(2, 9));
    endcase
  endfunction

  function automatic logic [pld_pkg::BOUND_W-1:0] pick_bound();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return pld_pkg::BOUND_W'($urandom);
    endcase
  endfunction

  // Loss draws land on and just under the active thresholds now and then,
  // where an off-by-one in the compare would show.
  function automatic logic [pld_pkg::DRAW_W-1:0] pick_loss_draw();
    logic [pld_pkg::RATE_W-1:0] threshold;
    threshold = $urandom_range(1) ? cur_rate : cur_after_loss;
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return pld_pkg::DRAW_W'(threshold - 17'd1);
      3:       return pld_pkg::DRAW_W'(threshold);
      default: return pld_pkg::DRAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [pld_pkg::DRAW_W-1:0] pick_delay_draw();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return pld_pkg::DRAW_W'($urandom);
    endcase
  endfunction

  initial begin
    pld_pkg::loss_mode_t mode;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Defaults after reset: no loss, no delay.
    send_packet(16'h0000, 16'h0000);
    send_packet(16'hFFFF, 16'hFFFF);

    // A rate of one loses everything; the full delay range hits both ends.
    program_emulator(pld_pkg::LOSS_INDEP, 17'h10000, 17'h00000, 16'd1, 1'b1,
                     16'h0000, 16'hFFFF);
    send_packet(16'h0000, 16'h0000);
    send_packet(16'hFFFF, 16'hFFFF);

    // A rate of zero never loses; the delay bounds are given reversed.
    program_emulator(pld_pkg::LOSS_INDEP, 17'h00000, 17'h00000, 16'd1, 1'b1,
                     16'hFFFF, 16'h0000);
    send_packet(16'h0000, 16'h8000);
    send_packet(16'hFFFF, 16'hFFFF);

    // Markov: the threshold follows the previous decision. Equal bounds at
    // the top of the range give a single possible delay.
    program_emulator(pld_pkg::LOSS_MARKOV, 17'h04000, 17'h08000, 16'd1, 1'b1,
                     16'hFFFF, 16'hFFFF);
    send_packet(16'h3FFF, pick_delay_draw());
    send_packet(16'h8000, pick_delay_draw());
    send_packet(16'h4000, pick_delay_draw());
    send_packet(16'h3FFF, pick_delay_draw());
    send_packet(16'h7FFF, pick_delay_draw());

    // Chained with a zero length: a fresh decision for every packet.
    program_emulator(pld_pkg::LOSS_CHAINED, 17'h08000, 17'h00000, 16'd0, 1'b0,
                     16'h0000, 16'h0000);
    send_packet(16'h0000, 16'h1234);
    send_packet(16'hFFFF, 16'h4321);

    // A chain of five starts lost and holds it despite high draws.
    program_emulator(pld_pkg::LOSS_CHAINED, 17'h08000, 17'h00000, 16'd5, 1'b1,
                     16'd100, 16'd200);
    send_packet(16'h0000, pick_delay_draw());
    send_packet(16'hFFFF, pick_delay_draw());
    send_packet(16'hFFFF, pick_delay_draw());

    // The length shrinks below the current position, so the chain wraps.
    program_emulator(pld_pkg::LOSS_CHAINED, 17'h08000, 17'h00000, 16'd2, 1'b1,
                     16'd200, 16'd100);
    send_packet(16'hFFFF, pick_delay_draw());
    send_packet(16'hFFFF, pick_delay_draw());

    // Mode none leaves the chain alone; back in chained mode the packet
    // continues the old chain instead of drawing afresh.
    program_emulator(pld_pkg::LOSS_NONE, 17'h08000, 17'h00000, 16'd2, 1'b0,
                     16'h0000, 16'h0000);
    send_packet(16'h0000, 16'hFFFF);
    program_emulator(pld_pkg::LOSS_CHAINED, 17'h08000, 17'h00000, 16'hFFFF, 1'b1,
                     16'h0000, 16'hFFFF);
    send_packet(16'h0000, 16'hFFFF);

    // Random part: three flow-control regimes, several settings in each.
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 20;
          recv_stall_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int setting = 0; setting < SETTINGS_PER_REGIME; setting++) begin
        // Markov and chained modes carry state, so they get extra weight.
        case ($urandom_range(5))
          0:       mode = pld_pkg::LOSS_NONE;
          1:       mode = pld_pkg::LOSS_INDEP;
          2, 3:    mode = pld_pkg::LOSS_MARKOV;
          default: mode = pld_pkg::LOSS_CHAINED;
        endcase
        program_emulator(mode, pick_rate(), pick_rate(), pick_chain_len(),
                         1'($urandom_range(1)), pick_bound(), pick_bound());
        for (int n = 0; n < PACKETS_PER_SETTING; n++) begin
          // Now and then the sender waits for the pipeline to run dry.
          if ((setting == 0 && n == PACKETS_PER_SETTING / 2) || $urandom_range(99) == 0) begin
            settle();
          end
          send_packet(pick_loss_draw(), pick_delay_draw());
        end
      end
    end

    settle();
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pld_pkg.sv
sv/pld_decide.sv
sv/packet_loss_delay_emulator.sv
bench/loss_delay_checker.sv
bench/testbench.sv
